@@ rtl/core/text_console_glyph_renderer_assert.svh @@
// Assertion macros shared by the text console glyph renderer RTL.
// Depends on nothing; users supply clk_i and rst_ni in scope.
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define TCGR_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tcgr assertion failed");
// Check that a condition implies another one on the next clock edge.
`define TCGR_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("tcgr assertion failed");
`else
`define TCGR_ASSERT(name, prop)
`define TCGR_ASSERT_NEXT(name, pre, post)
`endif

`endif

@@ rtl/core/tcgr_pkg.sv @@
// Shared types, constants and colour function of the glyph renderer.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package tcgr_pkg;

  localparam int unsigned FONT_AW    = 12;
  localparam int unsigned FONT_ROW_W = 4;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned PIX_IDX_W  = 24;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned COL_W      = 9;
  localparam int unsigned ROW_W      = 8;

  localparam logic [DIM_W-1:0] WIDTH_MIN  = 13'd8;
  localparam logic [DIM_W-1:0] WIDTH_MAX  = 13'd4096;
  localparam logic [DIM_W-1:0] HEIGHT_MIN = 13'd16;
  localparam logic [DIM_W-1:0] HEIGHT_MAX = 13'd4096;

  localparam logic [7:0] LEVEL_HI = 8'd255;
  localparam logic [7:0] LEVEL_LO = 8'd127;
  localparam logic [3:0] NIBBLE_MASK = 4'h0f;

  localparam logic [7:0] CHAR_BS = 8'd8;
  localparam logic [7:0] CHAR_LF = 8'd10;
  localparam logic [7:0] CHAR_CR = 8'd13;

  typedef enum logic [1:0] {
    CFG_ATTR   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KIND_CHAR = 1'b0,
    KIND_FONT = 1'b1
  } kind_e;

  // Font store port request from the sequencer.
  typedef struct packed {
    logic               we;
    logic [FONT_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic               re;
    logic [FONT_AW-1:0] raddr;
  } mem_req_t;

  // Glyph row waiting in the fetch stage.
  typedef struct packed {
    logic                 vld;
    logic [PIX_IDX_W-1:0] idx;
    logic                 last;
  } row_t;

  // Configuration register set.
  typedef struct packed {
    logic [7:0]       attr;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cfg_t;

  // Expand one attribute nibble into 0xRRGGBB.
  function automatic logic [COLOR_W-1:0] nibble_colour(logic [3:0] nib);
    logic [7:0] level;
    level = nib[3] ? LEVEL_HI : LEVEL_LO;
    return {(nib[2] ? level : 8'd0), (nib[1] ? level : 8'd0), (nib[0] ? level : 8'd0)};
  endfunction

endpackage

@@ rtl/core/tcgr_req_if.sv @@
// Input request channel of the glyph renderer: character or font write.
// Depends on nothing.
`timescale 1ns / 1ps

interface tcgr_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  char_code;
  logic [11:0] font_index;
  logic [7:0]  font_bits;

  modport source (output valid, kind, char_code, font_index, font_bits, input ready);
  modport sink   (input valid, kind, char_code, font_index, font_bits, output ready);
endinterface

@@ rtl/core/tcgr_pix_if.sv @@
// Output channel of the glyph renderer: one glyph row of eight colours.
// Depends on nothing.
`timescale 1ns / 1ps

interface tcgr_pix_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_index;
  logic [23:0] pixel_0;
  logic [23:0] pixel_1;
  logic [23:0] pixel_2;
  logic [23:0] pixel_3;
  logic [23:0] pixel_4;
  logic [23:0] pixel_5;
  logic [23:0] pixel_6;
  logic [23:0] pixel_7;
  logic        last;

  modport source (output valid, pixel_index, pixel_0, pixel_1, pixel_2, pixel_3,
                  pixel_4, pixel_5, pixel_6, pixel_7, last, input ready);
  modport sink   (input valid, pixel_index, pixel_0, pixel_1, pixel_2, pixel_3,
                  pixel_4, pixel_5, pixel_6, pixel_7, last, output ready);
endinterface

@@ rtl/core/tcgr_cfg_if.sv @@
// Configuration write channel of the glyph renderer.
// Depends on nothing.
`timescale 1ns / 1ps

interface tcgr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/tcgr_font_mem.sv @@
// 4096 x 8 font store with one write port and one registered read port.
// Depends on tcgr_pkg.
`timescale 1ns / 1ps

module tcgr_font_mem import tcgr_pkg::*; (
  input  logic       clk_i,
  input  mem_req_t   req_i,
  output logic [7:0] rdata_o
);

  localparam int unsigned DEPTH = 1 << FONT_AW;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  // Write glyph rows
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read and hold until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/tcgr_seq.sv @@
// Sequencer of the glyph renderer: cursor, row index accumulator, fetch stage.
// Depends on tcgr_pkg, tcgr_req_if and the assertion macro header.
`timescale 1ns / 1ps
`include "text_console_glyph_renderer_assert.svh"

module tcgr_seq import tcgr_pkg::*; #(
  parameter int unsigned GLYPH_HEIGHT = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcgr_req_if.sink  req_i,
  input  cfg_t      cfg_i,
  input  logic      take_i,
  output mem_req_t  mem_o,
  output row_t      row_o
);

  localparam int unsigned YW = $clog2(GLYPH_HEIGHT);
  localparam int unsigned LW = ROW_W + $clog2(GLYPH_HEIGHT);
  localparam logic [YW-1:0] Y_LAST = YW'(GLYPH_HEIGHT - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_BASE = 3'b010,
    ST_ROW  = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [COL_W-1:0]     col_q, col_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [7:0]           char_q, char_d;
  logic [YW-1:0]        y_q, y_d;
  logic [PIX_IDX_W-1:0] acc_q, acc_d;
  logic                 f_vld_q, f_vld_d;
  logic [PIX_IDX_W-1:0] f_idx_q, f_idx_d;
  logic                 f_last_q, f_last_d;

  logic [DIM_W-1:0]     w_eff, h_eff;
  logic [COL_W:0]       cols;
  logic [COL_W:0]       col_next;
  logic [DIM_W:0]       lf_need;
  logic                 lf_step;
  logic [ROW_W-1:0]     lf_row;
  logic [LW-1:0]        line;
  logic [LW+DIM_W-1:0]  prod;
  logic [PIX_IDX_W-1:0] base;
  logic                 accept, issue, y_last;

  // Clamp the screen size
  always_comb begin
    w_eff = cfg_i.width;
    if (w_eff < WIDTH_MIN) w_eff = WIDTH_MIN;
    if (w_eff > WIDTH_MAX) w_eff = WIDTH_MAX;
    h_eff = cfg_i.height;
    if (h_eff < HEIGHT_MIN) h_eff = HEIGHT_MIN;
    if (h_eff > HEIGHT_MAX) h_eff = HEIGHT_MAX;
  end

  assign cols     = w_eff[DIM_W-1:3];
  assign col_next = {1'b0, col_q} + 1'b1;

  // Step down a row only when a further full glyph row fits and the grid allows it
  assign lf_need = (DIM_W+1)'(({1'b0, row_q} + 9'd2) * GLYPH_HEIGHT);
  assign lf_step = (row_q != {ROW_W{1'b1}}) && (lf_need <= {1'b0, h_eff});
  assign lf_row  = lf_step ? row_q + 1'b1 : row_q;

  // Start index of the first glyph row
  assign line = LW'(row_q * GLYPH_HEIGHT);
  assign prod = line * w_eff;
  assign base = PIX_IDX_W'(prod) + PIX_IDX_W'({col_q, 3'b000});

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign y_last      = (y_q == Y_LAST);
  assign issue       = (state_q == ST_ROW) && (!f_vld_q || take_i);

  // Sequence the request
  always_comb begin
    state_d  = state_q;
    col_d    = col_q;
    row_d    = row_q;
    char_d   = char_q;
    y_d      = y_q;
    acc_d    = acc_q;
    f_idx_d  = f_idx_q;
    f_last_d = f_last_q;
    f_vld_d  = f_vld_q;
    if (take_i) f_vld_d = 1'b0;

    mem_o.we    = 1'b0;
    mem_o.waddr = req_i.font_index;
    mem_o.wdata = req_i.font_bits;
    mem_o.re    = issue;
    mem_o.raddr = {char_q, FONT_ROW_W'(y_q)};

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.kind == KIND_FONT) begin
            mem_o.we = 1'b1;
          end else begin
            case (req_i.char_code)
              CHAR_LF: begin
                row_d = lf_row;
                col_d = '0;
              end
              CHAR_CR: col_d = '0;
              CHAR_BS: begin
                if (col_q == '0) begin
                  if (row_q != '0) begin
                    row_d = row_q - 1'b1;
                    col_d = COL_W'(cols - 1'b1);
                  end
                end else begin
                  col_d = col_q - 1'b1;
                end
              end
              default: begin
                char_d  = req_i.char_code;
                y_d     = '0;
                state_d = ST_BASE;
              end
            endcase
          end
        end
      end
      ST_BASE: begin
        acc_d   = base;
        state_d = ST_ROW;
      end
      ST_ROW: begin
        if (issue) begin
          f_vld_d  = 1'b1;
          f_idx_d  = acc_q;
          f_last_d = y_last;
          acc_d    = acc_q + PIX_IDX_W'(w_eff);
          y_d      = y_q + 1'b1;
          if (y_last) begin
            // Advance the cursor, wrapping like a line feed
            if (col_next >= cols) begin
              row_d = lf_row;
              col_d = '0;
            end else begin
              col_d = col_next[COL_W-1:0];
            end
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      f_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      f_vld_q <= f_vld_d;
    end
  end

  // Hold working payload
  always_ff @(posedge clk_i) begin
    char_q   <= char_d;
    y_q      <= y_d;
    acc_q    <= acc_d;
    f_idx_q  <= f_idx_d;
    f_last_q <= f_last_d;
  end

  assign row_o.vld  = f_vld_q;
  assign row_o.idx  = f_idx_q;
  assign row_o.last = f_last_q;

  `TCGR_ASSERT_NEXT(a_fetch_hold, f_vld_q && !take_i, f_vld_q && $stable(f_idx_q))
  `TCGR_ASSERT(a_take_needs_row, !take_i || f_vld_q)
  `TCGR_ASSERT_NEXT(a_base_to_row, state_q == ST_BASE, state_q == ST_ROW)
  `TCGR_ASSERT_NEXT(a_last_to_idle, issue && y_last, state_q == ST_IDLE && f_last_q)

endmodule

@@ rtl/core/tcgr_out_stage.sv @@
// Output register of the glyph renderer: turns font bits into colours.
// Depends on tcgr_pkg and tcgr_pix_if.
`timescale 1ns / 1ps

module tcgr_out_stage import tcgr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  row_t       row_i,
  input  logic [7:0] bits_i,
  input  logic [7:0] attr_i,
  output logic       take_o,
  tcgr_pix_if.source pix_o
);

  logic                 out_vld_q;
  logic [PIX_IDX_W-1:0] idx_q;
  logic [COLOR_W-1:0]   pix_q [8];
  logic                 last_q;
  logic [COLOR_W-1:0]   fg, bg;

  assign fg     = nibble_colour(attr_i[3:0] & NIBBLE_MASK);
  assign bg     = nibble_colour(attr_i[7:4] & NIBBLE_MASK);
  assign take_o = row_i.vld && (!out_vld_q || pix_o.ready);

  // Advance the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (take_o) begin
      out_vld_q <= 1'b1;
    end else if (pix_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Load the row colours
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      idx_q  <= row_i.idx;
      last_q <= row_i.last;
      for (int x = 0; x < 8; x++) begin
        pix_q[x] <= bits_i[x] ? fg : bg;
      end
    end
  end

  assign pix_o.valid       = out_vld_q;
  assign pix_o.pixel_index = idx_q;
  assign pix_o.pixel_0     = pix_q[0];
  assign pix_o.pixel_1     = pix_q[1];
  assign pix_o.pixel_2     = pix_q[2];
  assign pix_o.pixel_3     = pix_q[3];
  assign pix_o.pixel_4     = pix_q[4];
  assign pix_o.pixel_5     = pix_q[5];
  assign pix_o.pixel_6     = pix_q[6];
  assign pix_o.pixel_7     = pix_q[7];
  assign pix_o.last        = last_q;

endmodule

@@ rtl/core/text_console_glyph_renderer.sv @@
// Text console glyph renderer: control characters move the cursor, font
// writes fill the store, other characters become GLYPH_HEIGHT row requests.
// Font writes, LF, CR and backspace complete on acceptance; a drawn character keeps
// the block busy through the base and row states, the sequencer issuing one font
// store read per cycle while the fetch stage is empty or being taken by the output.
// Reset clears cursor and handshake state; font store is not cleared.
`timescale 1ns / 1ps

module text_console_glyph_renderer import tcgr_pkg::*; #(
  parameter int unsigned GLYPH_HEIGHT = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcgr_req_if.sink   req_i,
  tcgr_pix_if.source pix_o,
  tcgr_cfg_if.sink   cfg_i
);

  cfg_t       cfg_q;
  mem_req_t   mem_req;
  row_t       row;
  logic [7:0] rdata;
  logic       take;

  // Accept configuration writes at any time
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attr   <= 8'd15;
      cfg_q.width  <= 13'd2048;
      cfg_q.height <= 13'd800;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ATTR:   cfg_q.attr   <= cfg_i.data[7:0];
        CFG_WIDTH:  cfg_q.width  <= cfg_i.data;
        CFG_HEIGHT: cfg_q.height <= cfg_i.data;
        default: ;
      endcase
    end
  end

  tcgr_seq #(
    .GLYPH_HEIGHT(GLYPH_HEIGHT)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cfg_i  (cfg_q),
    .take_i (take),
    .mem_o  (mem_req),
    .row_o  (row)
  );

  tcgr_font_mem u_font_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  tcgr_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .row_i  (row),
    .bits_i (rdata),
    .attr_i (cfg_q.attr),
    .take_o (take),
    .pix_o  (pix_o)
  );

endmodule

@@ tb/text_console_glyph_renderer_tb.sv @@
// Self-checking testbench for the text console glyph renderer: drives cursor, font and
// register requests, predicts every glyph row and compares it with the block's output.
// Depends on tcgr_pkg, the three channel interfaces and text_console_glyph_renderer.
`timescale 1ns / 1ps

module text_console_glyph_renderer_tb;
  import tcgr_pkg::*;

  localparam int unsigned GLYPH_ROWS    = 16;
  localparam int unsigned ITEM_TARGET   = 410;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned HOLD_CYCLES   = 400;

  typedef struct packed {
    logic [23:0]      pixel_index;
    logic [7:0][23:0] colour;
    logic             last;
  } glyph_row_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] code;
    logic [11:0] addr;
    logic [7:0] bits;
  } console_req_t;

  logic clk_i;
  logic rst_ni;

  tcgr_req_if req_ch ();
  tcgr_pix_if pix_ch ();
  tcgr_cfg_if cfg_ch ();

  text_console_glyph_renderer #(
    .GLYPH_HEIGHT(GLYPH_ROWS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .pix_o (pix_ch),
    .cfg_i (cfg_ch)
  );

  // Console state as the block should hold it
  logic [7:0]  attr_q;
  logic [12:0] width_q;
  logic [12:0] height_q;
  logic [8:0]  cur_col;
  logic [7:0]  cur_row;
  logic [7:0]  font_rows [4096];
  bit          font_known [4096];
  logic [7:0]  glyphs_loaded [$];
  glyph_row_t  rows_due [$];

  int unsigned error_count;
  int unsigned items_sent;
  int unsigned cycle_count;
  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;
  int unsigned receiver_hold;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned screen_px_wide();
    int unsigned w;
    w = width_q;
    if (w < 8) w = 8;
    if (w > 4096) w = 4096;
    return w;
  endfunction

  function automatic int unsigned grid_cols();
    return screen_px_wide() / 8;
  endfunction

  function automatic int unsigned grid_rows();
    int unsigned h;
    int unsigned r;
    h = height_q;
    if (h < 16) h = 16;
    if (h > 4096) h = 4096;
    r = h / GLYPH_ROWS;
    if (r > 256) r = 256;
    return r;
  endfunction

  // Expand one attribute nibble: bit3 picks full or half level, bits 2..0 are R, G, B
  function automatic logic [23:0] attr_colour(logic [3:0] nib);
    logic [7:0] level;
    level = nib[3] ? 8'hFF : 8'h7F;
    return {{8{nib[2]}} & level, {8{nib[1]}} & level, {8{nib[0]}} & level};
  endfunction

  function automatic bit glyph_ready(logic [7:0] c);
    for (int y = 0; y < GLYPH_ROWS; y++) begin
      if (!font_known[{c, 4'(y)}]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Move down a row unless on the last one; no scrolling
  function automatic void feed_line();
    if (int'(cur_row) + 1 < int'(grid_rows())) cur_row = cur_row + 8'd1;
    cur_col = '0;
  endfunction

  function automatic void apply_setting(cfg_idx_e idx, logic [12:0] data);
    case (idx)
      CFG_ATTR: attr_q = data[7:0];
      CFG_WIDTH: width_q = data;
      CFG_HEIGHT: height_q = data;
      default: ;
    endcase
  endfunction

  // Update the console state for one accepted request and queue its glyph rows
  function automatic void predict_console(console_req_t rq);
    logic [23:0] fg;
    logic [23:0] bg;
    logic [7:0]  bits;
    int unsigned w;
    int unsigned pix;
    glyph_row_t  r;
    if (rq.kind == KIND_FONT) begin
      font_rows[rq.addr] = rq.bits;
      font_known[rq.addr] = 1'b1;
      return;
    end
    case (rq.code)
      CHAR_LF: feed_line();
      CHAR_CR: cur_col = '0;
      CHAR_BS: begin
        if (cur_col == 0) begin
          if (cur_row != 0) begin
            cur_row = cur_row - 8'd1;
            cur_col = 9'(grid_cols() - 1);
          end
        end else begin
          cur_col = cur_col - 9'd1;
        end
      end
      default: begin
        fg = attr_colour(attr_q[3:0]);
        bg = attr_colour(attr_q[7:4]);
        w = screen_px_wide();
        for (int y = 0; y < GLYPH_ROWS; y++) begin
          bits = font_rows[{rq.code, 4'(y)}];
          pix = (int'(cur_row) * GLYPH_ROWS + y) * w + int'(cur_col) * 8;
          r.pixel_index = pix[23:0];
          for (int x = 0; x < 8; x++) r.colour[x] = bits[x] ? fg : bg;
          r.last = (y == GLYPH_ROWS - 1);
          rows_due.push_back(r);
        end
        // Advance the cursor; past the last column act as a line feed
        if (int'(cur_col) + 1 >= int'(grid_cols())) feed_line();
        else cur_col = cur_col + 9'd1;
      end
    endcase
  endfunction

  // Offer one request after a random gap and wait until it is taken
  task automatic push_request(console_req_t rq);
    int unsigned gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk_i);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_ch.valid      <= 1'b1;
    req_ch.kind       <= rq.kind;
    req_ch.char_code  <= rq.code;
    req_ch.font_index <= rq.addr;
    req_ch.font_bits  <= rq.bits;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    predict_console(rq);
    items_sent++;
  endtask

  task automatic send_font(logic [11:0] addr, logic [7:0] bits);
    console_req_t rq;
    rq.kind = KIND_FONT;
    rq.code = 8'($urandom);
    rq.addr = addr;
    rq.bits = bits;
    push_request(rq);
  endtask

  task automatic send_char(logic [7:0] code);
    console_req_t rq;
    rq.kind = KIND_CHAR;
    rq.code = code;
    rq.addr = 12'($urandom);
    rq.bits = 8'($urandom);
    push_request(rq);
  endtask

  task automatic load_glyph(logic [7:0] c);
    for (int y = 0; y < GLYPH_ROWS; y++) send_font({c, 4'(y)}, 8'($urandom));
    glyphs_loaded.push_back(c);
  endtask

  // Drop the request valid, wait for every glyph row, then let the block go quiet
  task automatic settle_console();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_setting(cfg_idx_e idx, logic [12:0] data);
    settle_console();
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    apply_setting(idx, data);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [12:0] pick_dimension(int unsigned floor_px);
    case ($urandom_range(5))
      0: return 13'($urandom_range(floor_px - 1, 0));
      1: return 13'($urandom_range(floor_px * 8, floor_px));
      2: return 13'($urandom_range(4096, floor_px));
      3: return 13'd4096;
      4: return 13'($urandom_range(8191, 4097));
      default: return 13'(floor_px);
    endcase
  endfunction

  task automatic retune_console();
    write_setting(CFG_ATTR, 13'($urandom_range(255)));
    write_setting(CFG_WIDTH, pick_dimension(8));
    write_setting(CFG_HEIGHT, pick_dimension(16));
  endtask

  // Draw a character, loading its glyph first if any row is still unwritten
  task automatic draw_any();
    logic [7:0] c;
    if (glyphs_loaded.size() > 0 && $urandom_range(9) < 8) begin
      c = glyphs_loaded[$urandom_range(glyphs_loaded.size() - 1)];
    end else begin
      c = 8'($urandom_range(255));
      if (c == CHAR_LF || c == CHAR_CR || c == CHAR_BS) c = c ^ 8'h80;
    end
    if (!glyph_ready(c)) load_glyph(c);
    send_char(c);
  endtask

  task automatic random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) send_font(12'($urandom), 8'($urandom));
    else if (pick < 18) send_char(CHAR_LF);
    else if (pick < 23) send_char(CHAR_CR);
    else if (pick < 31) send_char(CHAR_BS);
    else draw_any();
  endtask

  // Fill glyphs with solid, striped and random rows, touching both ends of the store
  task automatic test_font_load();
    for (int y = 0; y < GLYPH_ROWS; y++) send_font({8'h00, 4'(y)}, y[0] ? 8'hFF : 8'h00);
    for (int y = 0; y < GLYPH_ROWS; y++) send_font({8'hFF, 4'(y)}, y[0] ? 8'h55 : 8'hAA);
    glyphs_loaded.push_back(8'h00);
    glyphs_loaded.push_back(8'hFF);
    load_glyph(8'h41);
  endtask

  task automatic test_cursor_moves();
    send_char(8'h41);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CHAR_CR);
    // backspace at the top left does nothing
    send_char(CHAR_BS);
    send_char(CHAR_LF);
    // backspace at column 0 goes to the end of the previous row
    send_char(CHAR_BS);
    // drawing in the last column wraps to the next row
    send_char(8'hFF);
    send_char(8'h41);
    send_char(CHAR_BS);
  endtask

  task automatic test_setting_extremes();
    write_setting(CFG_ATTR, 13'h0000);
    send_char(8'h41);
    // upper data bits of the attribute are dropped
    write_setting(CFG_ATTR, 13'h1FFF);
    send_char(8'h00);
    write_setting(CFG_ATTR, 13'h07A);
    send_char(8'hFF);
    // width below the floor gives a single column
    write_setting(CFG_WIDTH, 13'd0);
    send_char(8'h41);
    // height below the floor gives one row; the cursor now sits below the grid
    write_setting(CFG_HEIGHT, 13'd0);
    send_char(8'hFF);
    send_char(CHAR_LF);
    send_char(CHAR_BS);
    write_setting(CFG_WIDTH, 13'd8191);
    write_setting(CFG_HEIGHT, 13'd8191);
    send_char(CHAR_LF);
    send_char(CHAR_BS);
    send_char(8'h00);
    send_char(CHAR_LF);
    send_char(CHAR_BS);
    // shrink the grid under a far-right cursor
    write_setting(CFG_WIDTH, 13'd64);
    send_char(8'h41);
    send_char(CHAR_BS);
    write_setting(CFG_HEIGHT, 13'd32);
    send_char(CHAR_LF);
    send_char(CHAR_LF);
    send_char(8'h00);
    write_setting(CFG_HEIGHT, 13'd4097);
    write_setting(CFG_WIDTH, 13'd4097);
    write_setting(CFG_HEIGHT, 13'd15);
    write_setting(CFG_WIDTH, 13'd7);
    send_char(8'hFF);
    write_setting(CFG_WIDTH, 13'd4096);
    write_setting(CFG_HEIGHT, 13'd4096);
    write_setting(CFG_ATTR, 13'h01E);
  endtask

  task automatic test_random_traffic(int unsigned goal);
    while (items_sent < goal) random_item();
  endtask

  // Drive pix ready: honor a long hold first, otherwise stall at random
  always @(negedge clk_i) begin
    if (receiver_hold > 0) begin
      pix_ch.ready <= 1'b0;
      receiver_hold = receiver_hold - 1;
    end else begin
      pix_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Compare each accepted glyph row with the oldest prediction
  always @(posedge clk_i) begin : check_glyph_rows
    glyph_row_t due;
    glyph_row_t seen;
    if (rst_ni && pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) begin
      seen.pixel_index = pix_ch.pixel_index;
      seen.colour = {pix_ch.pixel_7, pix_ch.pixel_6, pix_ch.pixel_5, pix_ch.pixel_4,
                     pix_ch.pixel_3, pix_ch.pixel_2, pix_ch.pixel_1, pix_ch.pixel_0};
      seen.last = pix_ch.last;
      if (rows_due.size() == 0) begin
        $display("%0t: unexpected glyph row, pixel_index %h", $time, seen.pixel_index);
        error_count++;
      end else begin
        due = rows_due.pop_front();
        if (seen.pixel_index !== due.pixel_index) begin
          $display("%0t: pixel_index mismatch, expected %h got %h",
                   $time, due.pixel_index, seen.pixel_index);
          error_count++;
        end
        for (int x = 0; x < 8; x++) begin
          if (seen.colour[x] !== due.colour[x]) begin
            $display("%0t: pixel_%0d mismatch at index %h, expected %h got %h",
                     $time, x, due.pixel_index, due.colour[x], seen.colour[x]);
            error_count++;
          end
        end
        if (seen.last !== due.last) begin
          $display("%0t: last mismatch at index %h, expected %b got %b",
                   $time, due.pixel_index, due.last, seen.last);
          error_count++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL text_console_glyph_renderer");
      $finish;
    end
  end

  initial begin
    int unsigned base;
    int unsigned step;
    rst_ni            = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.kind       = KIND_CHAR;
    req_ch.char_code  = '0;
    req_ch.font_index = '0;
    req_ch.font_bits  = '0;
    pix_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_ATTR;
    cfg_ch.data       = '0;
    attr_q            = 8'd15;
    width_q           = 13'd2048;
    height_q          = 13'd800;
    cur_col           = '0;
    cur_row           = '0;
    error_count       = 0;
    items_sent        = 0;
    cycle_count       = 0;
    receiver_hold     = 0;
    sender_idle_pct   = 35;
    receiver_idle_pct = 52;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_font_load();
    test_cursor_moves();
    test_setting_extremes();

    base = items_sent;
    step = (ITEM_TARGET > base) ? (ITEM_TARGET - base) / 6 : 1;

    retune_console();
    test_random_traffic(base + step);
    retune_console();
    test_random_traffic(base + 2 * step);

    sender_idle_pct   = 52;
    receiver_idle_pct = 35;
    retune_console();
    // hold the output off while requests keep coming, so the input backs up
    receiver_hold = HOLD_CYCLES;
    test_random_traffic(base + 3 * step);
    retune_console();
    test_random_traffic(base + 4 * step);

    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    retune_console();
    test_random_traffic(base + 5 * step);
    retune_console();
    test_random_traffic(ITEM_TARGET);

    settle_console();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && rows_due.size() == 0) begin
      $display("PASS text_console_glyph_renderer");
    end else begin
      $display("FAIL text_console_glyph_renderer");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/tcgr_pkg.sv
rtl/core/tcgr_req_if.sv
rtl/core/tcgr_pix_if.sv
rtl/core/tcgr_cfg_if.sv
rtl/core/tcgr_font_mem.sv
rtl/core/tcgr_seq.sv
rtl/core/tcgr_out_stage.sv
rtl/core/text_console_glyph_renderer.sv
tb/text_console_glyph_renderer_tb.sv
